// ===== rtl/core/button_short_long_press_classifier_unit_macros.svh =====
// Assertion macros for the button press classifier checkers.
// No dependencies; taken in by `include where assertions are written.
`ifndef BUTTON_SHORT_LONG_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_SHORT_LONG_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BSLPC_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define BSLPC_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bslpc_pkg.sv =====
// Shared constants and types for the button press classifier.
// No dependencies.
package bslpc_pkg;

	localparam int BUTTON_COUNT = 8;
	localparam int LANES        = 8;
	localparam int TIMER_W      = 16;
	localparam int IDX_W        = 3;
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;

	// Lanes that take part in a scan
	localparam logic [LANES-1:0] LANE_MASK = LANES'((16'd1 << BUTTON_COUNT) - 16'd1);

	localparam logic [TIMER_W-1:0] LONG_RESET  = 16'd1000;
	localparam logic [TIMER_W-1:0] SHORT_RESET = 16'd50;
	localparam logic [TIMER_W-1:0] TIMER_MAX   = '1;

	// Input commands
	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_SCAN = 1'b1
	} cmd_t;

	// Register index, taken from paddr[2]
	typedef enum logic {
		REG_LONG  = 1'b0,
		REG_SHORT = 1'b1
	} reg_idx_t;

	// Outcome of one scan against the current state
	typedef struct packed {
		logic [LANES-1:0]   ev_mask;
		logic [LANES-1:0]   ev_long;
		logic [LANES-1:0]   pressed_nxt;
		logic [LANES-1:0]   long_nxt;
		logic [TIMER_W-1:0] held_nxt;
	} eval_t;

endpackage

// ===== rtl/core/bslpc_if.sv =====
// Valid/ready channel interfaces for scan input and event output.
// Depends on bslpc_pkg.
interface bslpc_in_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [bslpc_pkg::LANES-1:0] button_bits;

	modport source (output valid, command, button_bits, input ready);
	modport sink   (input valid, command, button_bits, output ready);
endinterface

interface bslpc_out_if;
	logic                      valid;
	logic                      ready;
	logic [bslpc_pkg::IDX_W-1:0] button_index;
	logic                      is_long;
	logic                      last_event;

	modport source (output valid, button_index, is_long, last_event, input ready);
	modport sink   (input valid, button_index, is_long, last_event, output ready);
endinterface

// ===== rtl/core/bslpc_eval.sv =====
// Per-lane scan evaluation: events and next state for one scan.
// Depends on bslpc_pkg.
module bslpc_eval (
	input  logic [bslpc_pkg::LANES-1:0]   bits,
	input  logic [bslpc_pkg::LANES-1:0]   pressed,
	input  logic [bslpc_pkg::LANES-1:0]   lmask,
	input  logic [bslpc_pkg::TIMER_W-1:0] held,
	input  logic [bslpc_pkg::TIMER_W-1:0] long_ms,
	input  logic [bslpc_pkg::TIMER_W-1:0] short_ms,
	output bslpc_pkg::eval_t              res
);

	logic held_gt_long;
	logic held_ge_short;
	logic short_zero;

	// Threshold compares done once; a lane sees either held or zero
	assign held_gt_long  = held > long_ms;
	assign held_ge_short = held >= short_ms;
	assign short_zero    = short_ms == '0;

	// Lanes in index order; a new press zeroes the timer for higher lanes
	always_comb begin
		logic new_below;
		logic long_hit;
		logic short_ok;
		new_below       = 1'b0;
		long_hit        = 1'b0;
		short_ok        = 1'b0;
		res.ev_mask     = '0;
		res.ev_long     = '0;
		for (int i = 0; i < bslpc_pkg::LANES; i++) begin
			if (bslpc_pkg::LANE_MASK[i]) begin
				long_hit = !new_below && held_gt_long;
				short_ok = new_below ? short_zero : held_ge_short;
				if (bits[i]) begin
					if (pressed[i]) begin
						if (long_hit && !lmask[i]) begin
							res.ev_mask[i] = 1'b1;
							res.ev_long[i] = 1'b1;
						end
					end else begin
						new_below = 1'b1;
					end
				end else if (!lmask[i] && pressed[i] && short_ok) begin
					res.ev_mask[i] = 1'b1;
				end
			end
		end
		res.pressed_nxt = (bits & bslpc_pkg::LANE_MASK) | (pressed & ~bslpc_pkg::LANE_MASK);
		res.long_nxt    = (bits & (lmask | res.ev_long) & bslpc_pkg::LANE_MASK)
			| (lmask & ~bslpc_pkg::LANE_MASK);
		res.held_nxt    = new_below ? '0 : held;
	end

endmodule

// ===== rtl/core/button_short_long_press_classifier_unit.sv =====
// Path: each scan passes the input register; its events then transfer from the event register.
// Throughput: one item per cycle; a scan with n events holds the event register until all n
// have transferred, and a following scan that has events waits in the input register until it drains.
// Ticks and scans without events never wait on the output.
// Reset (arst_n low, asynchronous): masks, timer and queues clear, thresholds go to 1000 and 50.
module button_short_long_press_classifier_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	bslpc_in_if.sink                       req,
	bslpc_out_if.source                    evt,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bslpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bslpc_pkg::DATA_W-1:0]   pwdata,
	output logic [bslpc_pkg::DATA_W-1:0]   prdata,
	output logic                           pready
);

	logic                             valid_s1;
	logic                             cmd_s1;
	logic [bslpc_pkg::LANES-1:0]      bits_s1;
	logic [bslpc_pkg::LANES-1:0]      pressed_q;
	logic [bslpc_pkg::LANES-1:0]      long_q;
	logic [bslpc_pkg::TIMER_W-1:0]    held_q;
	logic [bslpc_pkg::TIMER_W-1:0]    long_ms_q;
	logic [bslpc_pkg::TIMER_W-1:0]    short_ms_q;
	logic [bslpc_pkg::LANES-1:0]      pend_q;
	logic [bslpc_pkg::LANES-1:0]      kind_q;
	bslpc_pkg::eval_t                 ev;
	logic                             in_xfer;
	logic                             out_xfer;
	logic                             is_scan;
	logic                             has_ev;
	logic                             drain_free;
	logic                             s1_adv;
	logic                             last_pend;
	logic                             cfg_wr;
	logic [bslpc_pkg::LANES-1:0]      pend_rest;
	logic [bslpc_pkg::IDX_W-1:0]      head_idx;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (bslpc_pkg::reg_idx_t'(paddr[2]) == bslpc_pkg::REG_SHORT)
		? bslpc_pkg::DATA_W'(short_ms_q) : bslpc_pkg::DATA_W'(long_ms_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ms_q  <= bslpc_pkg::LONG_RESET;
			short_ms_q <= bslpc_pkg::SHORT_RESET;
		end else if (cfg_wr) begin
			unique case (bslpc_pkg::reg_idx_t'(paddr[2]))
				bslpc_pkg::REG_LONG:  long_ms_q  <= pwdata[bslpc_pkg::TIMER_W-1:0];
				bslpc_pkg::REG_SHORT: short_ms_q <= pwdata[bslpc_pkg::TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	// Scan evaluation against current state
	bslpc_eval u_eval (
		.bits     (bits_s1),
		.pressed  (pressed_q),
		.lmask    (long_q),
		.held     (held_q),
		.long_ms  (long_ms_q),
		.short_ms (short_ms_q),
		.res      (ev)
	);

	// Event register head: lowest pending lane
	always_comb begin
		head_idx = '0;
		for (int i = bslpc_pkg::LANES - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				head_idx = bslpc_pkg::IDX_W'(i);
			end
		end
	end

	assign pend_rest  = pend_q & (pend_q - bslpc_pkg::LANES'(1));
	assign last_pend  = pend_rest == '0;
	assign out_xfer   = evt.valid && evt.ready;
	assign in_xfer    = req.valid && req.ready;
	assign is_scan    = bslpc_pkg::cmd_t'(cmd_s1) == bslpc_pkg::CMD_SCAN;
	assign has_ev     = is_scan && (ev.ev_mask != '0);
	assign drain_free = (pend_q == '0) || (out_xfer && last_pend);
	assign s1_adv     = valid_s1 && (!has_ev || drain_free);
	assign req.ready  = !valid_s1 || s1_adv;

	assign evt.valid        = pend_q != '0;
	assign evt.button_index = head_idx;
	assign evt.is_long      = kind_q[head_idx];
	assign evt.last_event   = last_pend;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= req.command;
			bits_s1 <= req.button_bits;
		end
	end

	// Press state and shared timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
			long_q    <= '0;
			held_q    <= '0;
		end else if (s1_adv) begin
			if (is_scan) begin
				pressed_q <= ev.pressed_nxt;
				long_q    <= ev.long_nxt;
				held_q    <= ev.held_nxt;
			end else if (held_q != bslpc_pkg::TIMER_MAX) begin
				held_q <= held_q + bslpc_pkg::TIMER_W'(1);
			end
		end
	end

	// Event register: drains lowest lane first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			kind_q <= '0;
		end else if (s1_adv && has_ev) begin
			pend_q <= ev.ev_mask;
			kind_q <= ev.ev_long;
		end else if (out_xfer) begin
			pend_q <= pend_rest;
		end
	end

endmodule

// ===== rtl/core/bslpc_checker.sv =====
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bslpc_pkg and the assertion macro header.
`include "button_short_long_press_classifier_unit_macros.svh"

module bslpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bslpc_pkg::IDX_W-1:0]   out_index,
	input logic                          out_long,
	input logic                          out_last
);

	// A waiting event keeps its payload
	`BSLPC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_index) && $stable(out_long) && $stable(out_last), "event changed while stalled")

	// A burst goes on until its last event
	`BSLPC_ASSERT_NXT(a_burst_cont, clk, arst_n, out_valid && out_ready && !out_last, out_valid, "burst ended before last event")

	// Events of one scan come in rising button order
	`BSLPC_ASSERT_NXT(a_burst_order, clk, arst_n, out_valid && out_ready && !out_last, out_index > $past(out_index), "burst out of order")

	// With nothing to drain the input side is open
	`BSLPC_ASSERT_IMP(a_ready_idle, clk, arst_n, !out_valid, in_ready, "input blocked while no event pending")

endmodule

bind button_short_long_press_classifier_unit bslpc_checker u_bslpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (req.ready),
	.out_valid (evt.valid),
	.out_ready (evt.ready),
	.out_index (evt.button_index),
	.out_long  (evt.is_long),
	.out_last  (evt.last_event)
);
